FILE: hdl/trtbp_pkg.sv
// shared types and constants for the two-rate token bucket policer
`default_nettype none

package trtbp_pkg;

  // flow table geometry
  localparam int FLOW_COUNT = 1024;
  localparam int FLOW_AW    = $clog2(FLOW_COUNT);
  localparam int INDEX_W    = 10;

  // field widths
  localparam int LEN_W   = 16;
  localparam int WORD_W  = 32;
  localparam int PROD_W  = 2 * WORD_W;
  localparam int VERD_W  = 2;

  // transaction actions
  localparam logic ACT_CONFIG = 1'b0;
  localparam logic ACT_POLICE = 1'b1;

  // verdict codes
  localparam logic [VERD_W-1:0] VERDICT_GREEN    = 2'd0;
  localparam logic [VERD_W-1:0] VERDICT_YELLOW   = 2'd1;
  localparam logic [VERD_W-1:0] VERDICT_RED      = 2'd2;
  localparam logic [VERD_W-1:0] VERDICT_NO_ENTRY = 2'd3;

  // per-flow bucket state, rewritten by every police transaction on a configured flow
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] stamp;
    logic [WORD_W-1:0] commit_tokens;
    logic [WORD_W-1:0] excess_tokens;
  } dyn_entry_t;

  // per-flow rates and bursts, written only by configure transactions
  typedef struct packed {
    logic [WORD_W-1:0] commit_bps;
    logic [WORD_W-1:0] commit_burst;
    logic [WORD_W-1:0] excess_bps;
    logic [WORD_W-1:0] excess_burst;
  } cfg_entry_t;

endpackage

`default_nettype wire

FILE: hdl/two_rate_token_bucket_policer.sv
// top level of the per-flow two-rate token bucket policer
//
// Input channel (in_valid / in_ready) carries configure and police transactions.
// A configure transaction loads a flow's rates and bursts, fills both buckets
// to their bursts and stamps the flow with in_now_seconds; it gives no result.
// A police transaction refills the flow's buckets for the elapsed seconds,
// marks the packet and charges the matching bucket; it gives one verdict on
// the output channel (out_valid / out_ready).
// A police transaction is accepted, then passes through table read, elapsed
// time, refill multiply, saturation and decision, and its verdict is registered
// as it leaves the decision step; the next transaction is taken only after
// that, since the flow's table entry is read, refilled through the two 32x32
// refill multipliers and written back in between.
// After reset the block sweeps the flow table once, one entry per cycle,
// marking every flow unconfigured: in_ready stays low until the sweep ends.
// A stalled output holds its verdict; the next transaction is still
// accepted and worked on, and waits in its decision step until the output
// register frees up.
`default_nettype none

module two_rate_token_bucket_policer (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output      logic                                in_ready,
  input  wire logic                                in_action,
  input  wire logic [trtbp_pkg::INDEX_W-1:0]       in_flow_index,
  input  wire logic [trtbp_pkg::LEN_W-1:0]         in_packet_length,
  input  wire logic [trtbp_pkg::WORD_W-1:0]        in_now_seconds,
  input  wire logic [trtbp_pkg::WORD_W-1:0]        in_commit_rate_in,
  input  wire logic [trtbp_pkg::WORD_W-1:0]        in_commit_burst_in,
  input  wire logic [trtbp_pkg::WORD_W-1:0]        in_excess_rate_in,
  input  wire logic [trtbp_pkg::WORD_W-1:0]        in_excess_burst_in,
  output      logic                                out_valid,
  input  wire logic                                out_ready,
  output      logic [trtbp_pkg::VERD_W-1:0]        out_verdict
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_SAT,
    ST_DECIDE
  } state_t;

  state_t                               state_r;
  logic [trtbp_pkg::FLOW_AW-1:0]        clr_addr_r;

  // captured police transaction
  logic [trtbp_pkg::FLOW_AW-1:0]        addr_r;
  logic                                 range_r;
  logic [trtbp_pkg::LEN_W-1:0]          len_r;
  logic [trtbp_pkg::WORD_W-1:0]         now_r;

  // working copy of the flow entry
  logic                                 ent_valid_r;
  logic [trtbp_pkg::WORD_W-1:0]         dt_r;
  logic [trtbp_pkg::WORD_W-1:0]         ctok_r;
  logic [trtbp_pkg::WORD_W-1:0]         etok_r;
  logic [trtbp_pkg::WORD_W-1:0]         crate_r;
  logic [trtbp_pkg::WORD_W-1:0]         erate_r;
  logic [trtbp_pkg::WORD_W-1:0]         cburst_r;
  logic [trtbp_pkg::WORD_W-1:0]         eburst_r;
  logic [trtbp_pkg::PROD_W-1:0]         cprod_r;
  logic [trtbp_pkg::PROD_W-1:0]         eprod_r;
  logic [trtbp_pkg::WORD_W-1:0]         cnew_r;
  logic [trtbp_pkg::WORD_W-1:0]         enew_r;

  logic                                 out_valid_r;
  logic [trtbp_pkg::VERD_W-1:0]         out_verdict_r;

  logic                                 in_acc;
  logic                                 in_range;
  logic                                 police_acc;
  logic                                 cfg_we;
  logic                                 clr_we;
  logic                                 upd_we;
  logic                                 out_free;
  logic [trtbp_pkg::FLOW_AW-1:0]        in_addr;

  logic                                 dyn_we;
  logic [trtbp_pkg::FLOW_AW-1:0]        dyn_waddr;
  trtbp_pkg::dyn_entry_t                dyn_wdata;
  trtbp_pkg::dyn_entry_t                dyn_rdata;
  trtbp_pkg::cfg_entry_t                cfg_wdata;
  trtbp_pkg::cfg_entry_t                cfg_rdata;

  logic [trtbp_pkg::PROD_W-1:0]         csum;
  logic [trtbp_pkg::PROD_W-1:0]         esum;
  logic [trtbp_pkg::WORD_W-1:0]         len_ext;
  logic [trtbp_pkg::WORD_W-1:0]         ctok_upd;
  logic [trtbp_pkg::WORD_W-1:0]         etok_upd;
  logic [trtbp_pkg::VERD_W-1:0]         verdict;

  // input handshake and table address
  assign in_ready   = (state_r == ST_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign in_addr    = trtbp_pkg::FLOW_AW'(in_flow_index);
  assign in_range   = (trtbp_pkg::WORD_W'(in_flow_index)
                       < trtbp_pkg::WORD_W'(trtbp_pkg::FLOW_COUNT));
  assign police_acc = in_acc && (in_action == trtbp_pkg::ACT_POLICE);
  assign cfg_we     = in_acc && (in_action == trtbp_pkg::ACT_CONFIG) && in_range;
  assign clr_we     = (state_r == ST_CLEAR);
  assign out_free   = !out_valid_r || out_ready;
  assign upd_we     = (state_r == ST_DECIDE) && out_free && ent_valid_r;

  // saturating refill sums
  assign csum = cprod_r + trtbp_pkg::PROD_W'(ctok_r);
  assign esum = eprod_r + trtbp_pkg::PROD_W'(etok_r);

  // color decision and bucket charge
  always_comb begin
    len_ext  = trtbp_pkg::WORD_W'(len_r);
    ctok_upd = cnew_r;
    etok_upd = enew_r;
    if (!ent_valid_r) begin
      verdict = trtbp_pkg::VERDICT_NO_ENTRY;
    end else if (len_ext <= cnew_r) begin
      verdict  = trtbp_pkg::VERDICT_GREEN;
      ctok_upd = cnew_r - len_ext;
    end else if (len_ext <= enew_r) begin
      verdict  = trtbp_pkg::VERDICT_YELLOW;
      etok_upd = enew_r - len_ext;
    end else begin
      verdict = trtbp_pkg::VERDICT_RED;
    end
  end

  // bucket table write port: clearing sweep, configure or write-back
  always_comb begin
    dyn_we    = clr_we || cfg_we || upd_we;
    dyn_waddr = addr_r;
    dyn_wdata = '0;
    if (clr_we) begin
      dyn_waddr = clr_addr_r;
    end else if (cfg_we) begin
      dyn_waddr               = in_addr;
      dyn_wdata.valid         = 1'b1;
      dyn_wdata.stamp         = in_now_seconds;
      dyn_wdata.commit_tokens = in_commit_burst_in;
      dyn_wdata.excess_tokens = in_excess_burst_in;
    end else begin
      dyn_wdata.valid         = 1'b1;
      dyn_wdata.stamp         = now_r;
      dyn_wdata.commit_tokens = ctok_upd;
      dyn_wdata.excess_tokens = etok_upd;
    end
  end

  // rate table write data
  always_comb begin
    cfg_wdata.commit_bps   = in_commit_rate_in;
    cfg_wdata.commit_burst = in_commit_burst_in;
    cfg_wdata.excess_bps   = in_excess_rate_in;
    cfg_wdata.excess_burst = in_excess_burst_in;
  end

  trtbp_ram #(
    .WIDTH ($bits(trtbp_pkg::dyn_entry_t)),
    .DEPTH (trtbp_pkg::FLOW_COUNT)
  ) u_dyn_ram (
    .clk   (clk),
    .we    (dyn_we),
    .waddr (dyn_waddr),
    .wdata (dyn_wdata),
    .re    (police_acc),
    .raddr (in_addr),
    .rdata (dyn_rdata)
  );

  trtbp_ram #(
    .WIDTH ($bits(trtbp_pkg::cfg_entry_t)),
    .DEPTH (trtbp_pkg::FLOW_COUNT)
  ) u_cfg_ram (
    .clk   (clk),
    .we    (cfg_we),
    .waddr (in_addr),
    .wdata (cfg_wdata),
    .re    (police_acc),
    .raddr (in_addr),
    .rdata (cfg_rdata)
  );

  // sequencer, working registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // output register: load a new verdict or retire the accepted one
      if ((state_r == ST_DECIDE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == trtbp_pkg::FLOW_AW'(trtbp_pkg::FLOW_COUNT - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (police_acc) begin
            addr_r  <= in_addr;
            range_r <= in_range;
            len_r   <= in_packet_length;
            now_r   <= in_now_seconds;
            state_r <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          ent_valid_r <= dyn_rdata.valid && range_r;
          dt_r        <= now_r - dyn_rdata.stamp;
          ctok_r      <= dyn_rdata.commit_tokens;
          etok_r      <= dyn_rdata.excess_tokens;
          crate_r     <= cfg_rdata.commit_bps;
          erate_r     <= cfg_rdata.excess_bps;
          cburst_r    <= cfg_rdata.commit_burst;
          eburst_r    <= cfg_rdata.excess_burst;
          state_r     <= ST_MUL;
        end
        ST_MUL: begin
          cprod_r <= trtbp_pkg::PROD_W'(crate_r) * trtbp_pkg::PROD_W'(dt_r);
          eprod_r <= trtbp_pkg::PROD_W'(erate_r) * trtbp_pkg::PROD_W'(dt_r);
          state_r <= ST_SAT;
        end
        ST_SAT: begin
          cnew_r  <= (csum >= trtbp_pkg::PROD_W'(cburst_r)) ? cburst_r
                                                             : csum[trtbp_pkg::WORD_W-1:0];
          enew_r  <= (esum >= trtbp_pkg::PROD_W'(eburst_r)) ? eburst_r
                                                             : esum[trtbp_pkg::WORD_W-1:0];
          state_r <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (out_free) begin
            out_verdict_r <= verdict;
            state_r       <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

  // no transaction is taken while the table is being swept
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_ready)
    else $error("input accepted during table sweep");

  // only one source drives the bucket table write port
  a_single_writer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({clr_we, cfg_we, upd_we}))
    else $error("bucket table write port contention");

  // an unconfigured flow leaves the table untouched
  a_no_entry_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DECIDE) && !ent_valid_r) |-> !dyn_we)
    else $error("write-back for unconfigured flow");

  // a finished decision presents a verdict and frees the sequencer
  a_decide_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DECIDE) && out_free) |=> (out_valid && (state_r == ST_IDLE)))
    else $error("decision did not reach the output register");

endmodule

`default_nettype wire

FILE: hdl/trtbp_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module trtbp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: test/trtbp_verdict_checker.sv
// verdict checker for the two-rate token bucket policer: predicts and compares
`timescale 1ns / 100ps

module trtbp_verdict_checker
  import trtbp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic                in_action,
  input  logic [INDEX_W-1:0]  in_flow_index,
  input  logic [LEN_W-1:0]    in_packet_length,
  input  logic [WORD_W-1:0]   in_now_seconds,
  input  logic [WORD_W-1:0]   in_commit_rate_in,
  input  logic [WORD_W-1:0]   in_commit_burst_in,
  input  logic [WORD_W-1:0]   in_excess_rate_in,
  input  logic [WORD_W-1:0]   in_excess_burst_in,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [VERD_W-1:0]   out_verdict,
  output int                  mismatch_total,
  output int                  verdicts_owed,
  output int                  green_seen,
  output int                  yellow_seen,
  output int                  red_seen,
  output int                  absent_seen,
  output int                  configs_seen
);

  // shadow flow table
  bit                flow_live    [FLOW_COUNT];
  logic [WORD_W-1:0] commit_left  [FLOW_COUNT];
  logic [WORD_W-1:0] excess_left  [FLOW_COUNT];
  logic [WORD_W-1:0] refill_stamp [FLOW_COUNT];
  logic [WORD_W-1:0] commit_pace  [FLOW_COUNT];
  logic [WORD_W-1:0] commit_cap   [FLOW_COUNT];
  logic [WORD_W-1:0] excess_pace  [FLOW_COUNT];
  logic [WORD_W-1:0] excess_cap   [FLOW_COUNT];

  // verdicts predicted but not yet seen on the output
  logic [VERD_W-1:0] verdicts_due [$];
  logic [VERD_W-1:0] wanted;

  // bucket top-up for elapsed seconds, exact product, clipped at the burst
  function automatic logic [WORD_W-1:0] topped_up(input logic [WORD_W-1:0] tokens,
                                                  input logic [WORD_W-1:0] rate,
                                                  input logic [WORD_W-1:0] secs,
                                                  input logic [WORD_W-1:0] burst);
    logic [PROD_W-1:0] sum;
    sum = PROD_W'(rate) * PROD_W'(secs) + PROD_W'(tokens);
    return (sum >= PROD_W'(burst)) ? burst : sum[WORD_W-1:0];
  endfunction

  // load a flow and fill both buckets
  function automatic void load_flow(input logic [INDEX_W-1:0] flow,
                                    input logic [WORD_W-1:0] now,
                                    input logic [WORD_W-1:0] cr,
                                    input logic [WORD_W-1:0] cb,
                                    input logic [WORD_W-1:0] er,
                                    input logic [WORD_W-1:0] eb);
    commit_pace[flow]  = cr;
    commit_cap[flow]   = cb;
    excess_pace[flow]  = er;
    excess_cap[flow]   = eb;
    commit_left[flow]  = cb;
    excess_left[flow]  = eb;
    refill_stamp[flow] = now;
    flow_live[flow]    = 1'b1;
  endfunction

  // refill, color the packet and charge the matching bucket
  function automatic logic [VERD_W-1:0] mark_packet(input logic [INDEX_W-1:0] flow,
                                                    input logic [LEN_W-1:0] len,
                                                    input logic [WORD_W-1:0] now);
    logic [WORD_W-1:0] elapsed;
    logic [WORD_W-1:0] bytes;
    if (!flow_live[flow]) return VERDICT_NO_ENTRY;
    elapsed = now - refill_stamp[flow];
    bytes   = WORD_W'(len);
    if (elapsed != '0) begin
      commit_left[flow]  = topped_up(commit_left[flow], commit_pace[flow], elapsed,
                                     commit_cap[flow]);
      excess_left[flow]  = topped_up(excess_left[flow], excess_pace[flow], elapsed,
                                     excess_cap[flow]);
      refill_stamp[flow] = now;
    end
    if (bytes <= commit_left[flow]) begin
      commit_left[flow] = commit_left[flow] - bytes;
      return VERDICT_GREEN;
    end
    if (bytes <= excess_left[flow]) begin
      excess_left[flow] = excess_left[flow] - bytes;
      return VERDICT_YELLOW;
    end
    return VERDICT_RED;
  endfunction

  // watch both channels; results are checked before the same-edge input is predicted
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FLOW_COUNT; i++) flow_live[i] = 1'b0;
      verdicts_due.delete();
      mismatch_total = 0;
      verdicts_owed  = 0;
      green_seen     = 0;
      yellow_seen    = 0;
      red_seen       = 0;
      absent_seen    = 0;
      configs_seen   = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: verdict %0d arrived with none expected", $time, out_verdict);
          mismatch_total++;
        end else begin
          wanted = verdicts_due.pop_front();
          if (out_verdict !== wanted) begin
            $display("%0t: verdict mismatch, expected %0d, actual %0d",
                     $time, wanted, out_verdict);
            mismatch_total++;
          end
        end
        case (out_verdict)
          VERDICT_GREEN:  green_seen++;
          VERDICT_YELLOW: yellow_seen++;
          VERDICT_RED:    red_seen++;
          default:        absent_seen++;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_action == ACT_CONFIG) begin
          load_flow(in_flow_index, in_now_seconds, in_commit_rate_in, in_commit_burst_in,
                    in_excess_rate_in, in_excess_burst_in);
          configs_seen++;
        end else begin
          verdicts_due.push_back(mark_packet(in_flow_index, in_packet_length,
                                             in_now_seconds));
        end
      end
      verdicts_owed = verdicts_due.size();
    end
  end

endmodule

FILE: test/tb_two_rate_token_bucket_policer.sv
// testbench top for the two-rate token bucket policer: stimulus, pacing and verdict
`timescale 1ns / 100ps

module tb_two_rate_token_bucket_policer;
  import trtbp_pkg::*;

  localparam int RANDOM_ITEMS = 880;
  localparam int CALM_ITEMS   = 150;
  localparam int POOL_SIZE    = 20;
  localparam int STALL_LIMIT  = 5000;
  localparam int LONG_HOLD    = 200;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                in_action;
  logic [INDEX_W-1:0]  in_flow_index;
  logic [LEN_W-1:0]    in_packet_length;
  logic [WORD_W-1:0]   in_now_seconds;
  logic [WORD_W-1:0]   in_commit_rate_in;
  logic [WORD_W-1:0]   in_commit_burst_in;
  logic [WORD_W-1:0]   in_excess_rate_in;
  logic [WORD_W-1:0]   in_excess_burst_in;
  logic                out_valid;
  logic                out_ready;
  logic [VERD_W-1:0]   out_verdict;

  int mismatch_total;
  int verdicts_owed;
  int green_seen;
  int yellow_seen;
  int red_seen;
  int absent_seen;
  int configs_seen;

  int items_sent = 0;
  bit calm       = 1'b0;
  bit held_long  = 1'b0;

  logic [INDEX_W-1:0] flow_pool [POOL_SIZE];
  logic [WORD_W-1:0]  wall_clock;

  two_rate_token_bucket_policer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_flow_index      (in_flow_index),
    .in_packet_length   (in_packet_length),
    .in_now_seconds     (in_now_seconds),
    .in_commit_rate_in  (in_commit_rate_in),
    .in_commit_burst_in (in_commit_burst_in),
    .in_excess_rate_in  (in_excess_rate_in),
    .in_excess_burst_in (in_excess_burst_in),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_verdict        (out_verdict)
  );

  trtbp_verdict_checker u_verdict_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_flow_index      (in_flow_index),
    .in_packet_length   (in_packet_length),
    .in_now_seconds     (in_now_seconds),
    .in_commit_rate_in  (in_commit_rate_in),
    .in_commit_burst_in (in_commit_burst_in),
    .in_excess_rate_in  (in_excess_rate_in),
    .in_excess_burst_in (in_excess_burst_in),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_verdict        (out_verdict),
    .mismatch_total     (mismatch_total),
    .verdicts_owed      (verdicts_owed),
    .green_seen         (green_seen),
    .yellow_seen        (yellow_seen),
    .red_seen           (red_seen),
    .absent_seen        (absent_seen),
    .configs_seen       (configs_seen)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // one transaction: drive at the falling edge, hold until accepted
  task automatic push_transaction(input logic act, input logic [INDEX_W-1:0] flow,
                                  input logic [LEN_W-1:0] len,
                                  input logic [WORD_W-1:0] now,
                                  input logic [WORD_W-1:0] cr,
                                  input logic [WORD_W-1:0] cb,
                                  input logic [WORD_W-1:0] er,
                                  input logic [WORD_W-1:0] eb);
    @(negedge clk);
    in_valid           <= 1'b1;
    in_action          <= act;
    in_flow_index      <= flow;
    in_packet_length   <= len;
    in_now_seconds     <= now;
    in_commit_rate_in  <= cr;
    in_commit_burst_in <= cb;
    in_excess_rate_in  <= er;
    in_excess_burst_in <= eb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic police(input logic [INDEX_W-1:0] flow, input logic [LEN_W-1:0] len,
                        input logic [WORD_W-1:0] now);
    push_transaction(ACT_POLICE, flow, len, now, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic configure(input logic [INDEX_W-1:0] flow, input logic [WORD_W-1:0] now,
                           input logic [WORD_W-1:0] cr, input logic [WORD_W-1:0] cb,
                           input logic [WORD_W-1:0] er, input logic [WORD_W-1:0] eb);
    push_transaction(ACT_CONFIG, flow, LEN_W'($urandom), now, cr, cb, er, eb);
  endtask

  // drop valid for a number of cycles
  task automatic idle_for(input int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // drop valid until every predicted verdict has come back
  task automatic drain_verdicts();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdicts_owed != 0) @(negedge clk);
  endtask

  // mostly sized to give a mix of colors, sometimes full range or an extreme
  function automatic logic [WORD_W-1:0] pick_word(input int narrow_max);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 4)  return $urandom;
    return $urandom_range(0, narrow_max);
  endfunction

  function automatic logic [LEN_W-1:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3)  return '0;
    if (r < 6)  return '1;
    if (r < 16) return LEN_W'($urandom);
    return LEN_W'($urandom_range(0, 2000));
  endfunction

  // time mostly stands still or ticks, sometimes jumps anywhere
  function automatic logic [WORD_W-1:0] advance_clock(input logic [WORD_W-1:0] now);
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return now;
    if (r < 90) return now + 1;
    if (r < 95) return now + $urandom_range(2, 50);
    return $urandom;
  endfunction

  // output side: random stalls, one long hold, none near the end
  initial begin
    int hold;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_long && items_sent >= 300) begin
        out_ready <= 1'b0;
        held_long = 1'b1;
        hold = LONG_HOLD;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        out_ready <= 1'b0;
        hold = $urandom_range(1, 11);
      end else begin
        out_ready <= 1'b1;
        hold = $urandom_range(1, 20);
      end
      repeat (hold - 1) @(negedge clk);
    end
  end

  // watchdog on cycles with no accepted transaction on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // stimulus and final verdict
  initial begin
    int r;
    logic [INDEX_W-1:0] flow;
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_action          = ACT_CONFIG;
    in_flow_index      = '0;
    in_packet_length   = '0;
    in_now_seconds     = '0;
    in_commit_rate_in  = '0;
    in_commit_burst_in = '0;
    in_excess_rate_in  = '0;
    in_excess_burst_in = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: unconfigured flow, color boundaries, zero length
    police(10'd5, 16'd100, 32'd100);
    configure(10'd0, 32'd100, 32'd1000, 32'd1500, 32'd500, 32'd2000);
    police(10'd0, 16'd0, 32'd100);
    police(10'd0, 16'd1500, 32'd100);
    police(10'd0, 16'd1, 32'd100);
    police(10'd0, 16'hFFFF, 32'd100);
    police(10'd0, 16'd1000, 32'd101);
    // time going backwards counts as a huge elapsed time
    police(10'd0, 16'd100, 32'd99);
    // widest values, refill that overflows 32 bits, clock wrap
    configure(10'd1023, 32'hFFFF_FFFF, '1, '1, '1, '1);
    police(10'd1023, 16'hFFFF, 32'd0);
    police(10'd1023, 16'd0, 32'h7FFF_FFFF);
    police(10'd1023, 16'hFFFF, 32'h7FFF_FFFF);
    // empty buckets
    configure(10'd1, 32'd0, '0, '0, '0, '0);
    police(10'd1, 16'd0, 32'd5);
    police(10'd1, 16'd1, 32'd6);
    // reconfigure refills both buckets
    configure(10'd0, 32'd7, 32'd0, 32'd100, 32'd0, 32'd100);
    police(10'd0, 16'd100, 32'd7);
    police(10'd0, 16'd100, 32'd7);
    police(10'd0, 16'd1, 32'd7);
    police(10'd0, 16'd1, 32'd8);
    drain_verdicts();

    // random: a pool of live flows, edges of the table among them
    flow_pool[0] = '0;
    flow_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++)
      flow_pool[i] = INDEX_W'($urandom_range(0, FLOW_COUNT - 1));
    wall_clock = $urandom;
    for (int i = 0; i < POOL_SIZE; i++)
      configure(flow_pool[i], wall_clock, pick_word(1500), pick_word(4000),
                pick_word(1500), pick_word(6000));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) drain_verdicts();
      if (i == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      if (!calm && $urandom_range(0, 5) == 0) idle_for($urandom_range(1, 11));
      wall_clock = advance_clock(wall_clock);
      flow = flow_pool[$urandom_range(0, POOL_SIZE - 1)];
      r = $urandom_range(0, 99);
      if (r < 12)
        configure(flow, wall_clock, pick_word(1500), pick_word(4000),
                  pick_word(1500), pick_word(6000));
      else if (r < 90)
        police(flow, pick_length(), wall_clock);
      else if (r < 95)
        police(INDEX_W'($urandom_range(0, FLOW_COUNT - 1)), pick_length(), $urandom);
      else
        configure(INDEX_W'($urandom_range(0, FLOW_COUNT - 1)), $urandom, $urandom,
                  $urandom, $urandom, $urandom);
    end

    // wait out the pipeline
    drain_verdicts();
    repeat (20) @(negedge clk);

    $display("run covered %0d transactions, %0d of them configure", items_sent,
             configs_seen);
    $display("verdicts seen: green %0d, yellow %0d, red %0d, no entry %0d",
             green_seen, yellow_seen, red_seen, absent_seen);
    if (mismatch_total == 0 && verdicts_owed == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/trtbp_pkg.sv
hdl/trtbp_ram.sv
hdl/two_rate_token_bucket_policer.sv
test/trtbp_verdict_checker.sv
test/tb_two_rate_token_bucket_policer.sv
